FILE: hdl/vtao_pkg.sv
// Shared types, constants and the CORDIC angle table for the view-to-target offset block.
`default_nettype none

package vtao_pkg;

  // Internal angles are in 2^-20 degree; direction vectors are Q30.
  localparam int IA_FRAC      = 20;
  localparam int VEC_ONE_BITS = 30;
  localparam int CORDIC_ITERS = 26;
  localparam int ISQRT_STEPS  = 32;

  // Widths of the rotation datapaths.
  localparam int SC_XW = 34;
  localparam int AT_XW = 36;
  localparam int ZW    = 32;

  // Inverse CORDIC gain in Q30, the start value of the rotation.
  localparam logic signed [SC_XW-1:0] CORDIC_INV_GAIN = 34'sd652032874;

  // Ninety degrees in internal angle units.
  localparam logic signed [ZW-1:0] QUARTER_TURN = 32'sd94371840;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [ZW-1:0] ang_t;

  // Three normalized delta components, each 31-bit signed.
  typedef logic [2:0][30:0] uvec_t;

  // atan(2^-i) in 2^-20 degree.
  function automatic ang_t atan_step(input int i);
    ang_t r;
    case (i)
      0:  r = 32'sd47185920;
      1:  r = 32'sd27855475;
      2:  r = 32'sd14718068;
      3:  r = 32'sd7471121;
      4:  r = 32'sd3750058;
      5:  r = 32'sd1876857;
      6:  r = 32'sd938658;
      7:  r = 32'sd469357;
      8:  r = 32'sd234682;
      9:  r = 32'sd117342;
      10: r = 32'sd58671;
      11: r = 32'sd29335;
      12: r = 32'sd14668;
      13: r = 32'sd7334;
      14: r = 32'sd3667;
      15: r = 32'sd1833;
      16: r = 32'sd917;
      17: r = 32'sd458;
      18: r = 32'sd229;
      19: r = 32'sd115;
      20: r = 32'sd57;
      21: r = 32'sd29;
      22: r = 32'sd14;
      23: r = 32'sd7;
      24: r = 32'sd4;
      25: r = 32'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/vtao_sincos.sv
// Pipelined CORDIC that turns an angle in fractional degrees into Q30 cosine and sine.
`default_nettype none

module vtao_sincos #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] angle,
  output vtao_pkg::q30_t          cos_q,
  output vtao_pkg::q30_t          sin_q
);

  localparam int RW     = 26;
  localparam int ITERS  = vtao_pkg::CORDIC_ITERS;
  localparam int XW     = vtao_pkg::SC_XW;
  localparam int SH     = vtao_pkg::IA_FRAC - ANGLE_FRAC_BITS;
  localparam int FULL_I = 360 << ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] FULL  = RW'(FULL_I);
  localparam logic signed [RW-1:0] HALF  = RW'(FULL_I / 2);
  localparam logic signed [RW-1:0] QUART = RW'(FULL_I / 4);

  logic signed [RW-1:0] red;
  logic                 red_neg;
  vtao_pkg::ang_t       z_start;

  logic signed [XW-1:0] xs [0:ITERS];
  logic signed [XW-1:0] ys [0:ITERS];
  vtao_pkg::ang_t       zs [0:ITERS];
  logic                 ng [0:ITERS];

  // Wrap the angle into one turn, then fold it into the right half plane.
  always_comb begin
    red     = RW'(angle) + RW'(8 * FULL_I);
    red_neg = 1'b0;
    for (int k = 3; k >= 0; k--) begin
      if (red >= (FULL <<< k)) begin
        red = red - (FULL <<< k);
      end
    end
    if (red > HALF) begin
      red = red - FULL;
    end
    if (red > QUART) begin
      red     = red - HALF;
      red_neg = 1'b1;
    end else if (red < -QUART) begin
      red     = red + HALF;
      red_neg = 1'b1;
    end
    z_start = vtao_pkg::ang_t'(red) <<< SH;
  end

  // Entry register of the rotation pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= vtao_pkg::CORDIC_INV_GAIN;
      ys[0] <= '0;
      zs[0] <= z_start;
      ng[0] <= red_neg;
    end
  end

  // One rotation step per stage.
  for (genvar i = 0; i < ITERS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - vtao_pkg::atan_step(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + vtao_pkg::atan_step(i);
        end
        ng[i+1] <= ng[i];
      end
    end
  end

  // Undo the half-turn fold.
  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= ng[ITERS] ? 32'(-xs[ITERS]) : 32'(xs[ITERS]);
      sin_q <= ng[ITERS] ? 32'(-ys[ITERS]) : 32'(ys[ITERS]);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/vtao_atan2.sv
// Pipelined CORDIC vectoring unit giving atan2 of a nonnegative y and a signed x.
`default_nettype none

module vtao_atan2 (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic        [31:0] y_in,
  input  vtao_pkg::q30_t          x_in,
  output vtao_pkg::ang_t          angle
);

  localparam int ITERS = vtao_pkg::CORDIC_ITERS;
  localparam int XW    = vtao_pkg::AT_XW;

  logic signed [XW-1:0] xs [0:ITERS];
  logic signed [XW-1:0] ys [0:ITERS];
  vtao_pkg::ang_t       zs [0:ITERS];

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;

  assign x_ext = XW'(x_in);
  assign y_ext = $signed({{(XW-32){1'b0}}, y_in});

  // A vector in the left half plane is turned by ninety degrees first.
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        xs[0] <= y_ext;
        ys[0] <= -x_ext;
        zs[0] <= vtao_pkg::QUARTER_TURN;
      end else begin
        xs[0] <= x_ext;
        ys[0] <= y_ext;
        zs[0] <= '0;
      end
    end
  end

  // One vectoring step per stage, driving y toward zero.
  for (genvar i = 0; i < ITERS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + vtao_pkg::atan_step(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - vtao_pkg::atan_step(i);
        end
      end
    end
  end

  assign angle = zs[ITERS];

endmodule

`default_nettype wire

FILE: hdl/view_to_target_angular_offset.sv
// Top level of the view-to-target angular offset pipeline.
//
// Usage: one input channel (in_valid / in_stall) carries a view pitch and yaw
// and two 3-D points; one output channel (out_valid / out_stall) returns the
// angle between the view direction and the direction from source to target,
// in 1/2^ANGLE_FRAC_BITS degree, plus a flag for coincident points.
// From an accepted transaction to its result, the data passes through the
// sine/cosine CORDIC, the vector products, the square root
// (one result bit per stage), the atan2 CORDIC and rounding, in that order.
// Throughput is one transaction per cycle while the output is not stalled; every stage is a register.
// The whole pipeline advances together. When a result waits at the output and
// out_stall is high, the pipeline holds and in_stall is raised; otherwise a
// new transaction is taken every cycle, even while the output is occupied by
// a result that the receiver is taking.
// Reset clears the valid bits only; no results are produced until new
// transactions enter. There is no configuration and no other state.
`default_nettype none

module view_to_target_angular_offset #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] view_pitch,
  input  wire logic signed [15:0] view_yaw,
  input  wire logic signed [31:0] src_x,
  input  wire logic signed [31:0] src_y,
  input  wire logic signed [31:0] src_z,
  input  wire logic signed [31:0] dst_x,
  input  wire logic signed [31:0] dst_y,
  input  wire logic signed [31:0] dst_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [14:0] offset_angle,
  output logic                    degenerate
);

  localparam int SC_LAT = 28;
  localparam int STEPS  = vtao_pkg::ISQRT_STEPS;
  localparam int AT_LAT = vtao_pkg::CORDIC_ITERS + 1;
  localparam int LAT    = SC_LAT + 5 + STEPS + AT_LAT + 1;
  localparam int DU     = SC_LAT + 1 - 3;
  localparam int DD     = 2 + STEPS;
  localparam int SH     = vtao_pkg::IA_FRAC - ANGLE_FRAC_BITS;
  localparam int LIM_I  = 180 << ANGLE_FRAC_BITS;
  localparam int CAP_I  = (LIM_I > 32767) ? 32767 : LIM_I;
  localparam logic signed [32:0] RND = 33'sd1 <<< (SH - 1);
  localparam logic signed [32:0] CAP = 33'(CAP_I);

  logic en;

  logic [LAT-1:0] vld;
  logic [LAT-1:0] dg;
  logic           in_deg;

  logic signed [31:0] src_a [3];
  logic signed [31:0] dst_a [3];
  logic signed [32:0] dlt   [3];

  logic [31:0] mag1 [3];
  logic [2:0]  sgn1;
  logic [31:0] mag2 [3];
  logic [2:0]  sgn2;
  logic [5:0]  len2;
  logic [31:0] mx;
  logic [5:0]  len_next;
  vtao_pkg::uvec_t un_next;
  vtao_pkg::uvec_t un;
  vtao_pkg::uvec_t ud [0:DU-1];
  vtao_pkg::uvec_t uq;

  vtao_pkg::q30_t cp, sp, cy, sy;
  logic signed [63:0] pcc, pcs;
  vtao_pkg::q30_t v0, v1, v2;

  logic signed [63:0] pa, pb, pc, pd, pe, pf, pg, ph, pi;
  logic signed [63:0] dif0, dif1, dif2, dsum;
  vtao_pkg::q30_t cr0, cr1, cr2, dot;
  logic signed [63:0] s0, s1, s2;
  logic [63:0] sq;
  vtao_pkg::q30_t dd [0:DD-1];

  logic [63:0] iv [0:STEPS];
  logic [63:0] ir [0:STEPS];

  vtao_pkg::ang_t     z_at;
  logic signed [32:0] zc;
  logic signed [32:0] zr;

  // The pipeline moves unless a finished result is held at the output.
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // Valid and coincident-point bits travel alongside the datapath.
  assign in_deg = (src_x == dst_x) && (src_y == dst_y) && (src_z == dst_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg <= {dg[LAT-2:0], in_deg};
    end
  end

  assign out_valid  = vld[LAT-1];
  assign degenerate = dg[LAT-1];

  // Delta from source to target and its magnitudes.
  assign src_a[0] = src_x;
  assign src_a[1] = src_y;
  assign src_a[2] = src_z;
  assign dst_a[0] = dst_x;
  assign dst_a[1] = dst_y;
  assign dst_a[2] = dst_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dlt[k] = 33'(dst_a[k]) - 33'(src_a[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sgn1[k] <= dlt[k][32];
        mag1[k] <= dlt[k][32] ? 32'(-dlt[k]) : dlt[k][31:0];
      end
    end
  end

  // Bit length of the largest magnitude.
  always_comb begin
    mx = (mag1[0] > mag1[1]) ? mag1[0] : mag1[1];
    if (mag1[2] > mx) begin
      mx = mag1[2];
    end
    len_next = '0;
    for (int b = 0; b < 32; b++) begin
      if (mx[b]) begin
        len_next = 6'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2 <= mag1;
      sgn2 <= sgn1;
      len2 <= len_next;
    end
  end

  // Scale so the largest magnitude lands in [2^28, 2^29).
  always_comb begin
    logic [31:0] m;
    for (int k = 0; k < 3; k++) begin
      if (len2 > 6'd29) begin
        m = mag2[k] >> (len2 - 6'd29);
      end else begin
        m = mag2[k] << (6'd29 - len2);
      end
      un_next[k] = sgn2[k] ? 31'(-{2'b00, m[28:0]}) : {2'b00, m[28:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      un <= un_next;
    end
  end

  // Hold the normalized delta until the view vector is ready.
  always_ff @(posedge clk) begin
    if (en) begin
      ud[0] <= un;
      for (int k = 1; k < DU; k++) begin
        ud[k] <= ud[k-1];
      end
    end
  end

  assign uq = ud[DU-1];

  // Sine and cosine of the view angles.
  vtao_sincos #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_pitch (
    .clk  (clk),
    .en   (en),
    .angle(view_pitch),
    .cos_q(cp),
    .sin_q(sp)
  );

  vtao_sincos #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_yaw (
    .clk  (clk),
    .en   (en),
    .angle(view_yaw),
    .cos_q(cy),
    .sin_q(sy)
  );

  // View unit vector.
  assign pcc = cp * cy;
  assign pcs = sy * cp;

  always_ff @(posedge clk) begin
    if (en) begin
      v0 <= pcc[61:30];
      v1 <= pcs[61:30];
      v2 <= -sp;
    end
  end

  // Component products for the cross and dot products.
  always_ff @(posedge clk) begin
    if (en) begin
      pa <= v1 * $signed(uq[2]);
      pb <= v2 * $signed(uq[1]);
      pc <= v2 * $signed(uq[0]);
      pd <= v0 * $signed(uq[2]);
      pe <= v0 * $signed(uq[1]);
      pf <= v1 * $signed(uq[0]);
      pg <= v0 * $signed(uq[0]);
      ph <= v1 * $signed(uq[1]);
      pi <= v2 * $signed(uq[2]);
    end
  end

  // Cross product and dot product, back in Q30 scale.
  assign dif0 = pa - pb;
  assign dif1 = pc - pd;
  assign dif2 = pe - pf;
  assign dsum = pg + ph + pi;

  always_ff @(posedge clk) begin
    if (en) begin
      cr0 <= dif0[61:30];
      cr1 <= dif1[61:30];
      cr2 <= dif2[61:30];
      dot <= dsum[61:30];
    end
  end

  // Squared length of the cross product.
  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= cr0 * cr0;
      s1 <= cr1 * cr1;
      s2 <= cr2 * cr2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= 64'(s0) + 64'(s1) + 64'(s2);
    end
  end

  // Dot product waits for the square root.
  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= dot;
      for (int k = 1; k < DD; k++) begin
        dd[k] <= dd[k-1];
      end
    end
  end

  // Integer square root, one result bit per stage.
  assign iv[0] = sq;
  assign ir[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (iv[k] >= ir[k] + BIT) begin
          iv[k+1] <= iv[k] - (ir[k] + BIT);
          ir[k+1] <= (ir[k] >> 1) + BIT;
        end else begin
          iv[k+1] <= iv[k];
          ir[k+1] <= ir[k] >> 1;
        end
      end
    end
  end

  // Angle from sine and cosine parts.
  vtao_atan2 u_atan2 (
    .clk  (clk),
    .en   (en),
    .y_in (ir[STEPS][31:0]),
    .x_in (dd[DD-1]),
    .angle(z_at)
  );

  // Round to the output unit and clamp to half a turn.
  always_comb begin
    zc = (z_at < 0) ? '0 : 33'(z_at);
    zr = (zc + RND) >>> SH;
    if (zr > CAP) begin
      zr = CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      offset_angle <= dg[LAT-2] ? '0 : zr[14:0];
    end
  end

  // A coincident-point result always reports zero.
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (offset_angle == '0))
    else $error("degenerate result with nonzero angle");

  // The reported angle never exceeds half a turn.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({18'b0, offset_angle} <= 33'(CAP_I)))
    else $error("offset angle above clamp");

  // While the input is held off, no valid bit moves.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld))
    else $error("pipeline advanced during stall");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the view-to-target angular offset pipeline.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_BITS = 7;
  localparam int IA_SHIFT = 20;
  localparam int ONE_BITS = 30;
  localparam int STEPS = 26;
  localparam longint INV_GAIN = 64'sd652032874;
  localparam int LATENCY = 93;
  localparam int N_RANDOM = 1430;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } query_t;

  typedef struct packed {
    logic [14:0] angle;
    logic degen;
  } offset_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] view_pitch = '0;
  logic signed [15:0] view_yaw = '0;
  logic signed [31:0] src_x = '0, src_y = '0, src_z = '0;
  logic signed [31:0] dst_x = '0, dst_y = '0, dst_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] offset_angle;
  logic degenerate;

  query_t pending_queries[$];
  offset_t expected_offsets[$];
  int error_count = 0;
  longint cycle_count = 0;
  bit stimulus_done = 1'b0;
  bit in_busy = 1'b0;
  int hold_off_left = 0;
  int send_gap = 0;
  int recv_gap = 0;

  view_to_target_angular_offset dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .view_pitch(view_pitch), .view_yaw(view_yaw),
    .src_x(src_x), .src_y(src_y), .src_z(src_z),
    .dst_x(dst_x), .dst_y(dst_y), .dst_z(dst_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .offset_angle(offset_angle), .degenerate(degenerate)
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr(input longint v, input int s);
    return v >>> s;
  endfunction

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rotation CORDIC: view angle to cosine and sine in Q30.
  function automatic void cos_sin(input longint a, output longint c, output longint s);
    longint full, half, quart, z, x, y, t;
    bit flip;
    full = 64'sd360 <<< IA_SHIFT;
    half = 64'sd180 <<< IA_SHIFT;
    quart = 64'sd90 <<< IA_SHIFT;
    z = a * (64'sd1 <<< (IA_SHIFT - ANGLE_BITS));
    x = INV_GAIN;
    y = 0;
    flip = 1'b0;
    z = z % full;
    if (z < 0) z += full;
    if (z > half) z -= full;
    if (z > quart) begin
      z -= half;
      flip = 1'b1;
    end else if (z < -quart) begin
      z += half;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      t = x;
      if (z >= 0) begin
        x -= shr(y, i);
        y += shr(t, i);
        z -= longint'(vtao_pkg::atan_step(i));
      end else begin
        x += shr(y, i);
        y -= shr(t, i);
        z += longint'(vtao_pkg::atan_step(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Vectoring CORDIC: angle of (x, y) for y >= 0.
  function automatic longint vector_angle(input longint y, input longint x);
    longint z, t;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'sd90 <<< IA_SHIFT;
    end
    for (int i = 0; i < STEPS; i++) begin
      t = x;
      if (y >= 0) begin
        x += shr(y, i);
        y -= shr(t, i);
        z += longint'(vtao_pkg::atan_step(i));
      end else begin
        x -= shr(y, i);
        y += shr(t, i);
        z -= longint'(vtao_pkg::atan_step(i));
      end
    end
    return z;
  endfunction

  // Expected angle between the view direction and the source-to-target line.
  function automatic offset_t predict_offset(input query_t q);
    longint u[3], v[3], cr[3];
    longint unsigned mag[3], mx, m, sq;
    longint cp, sp, cy, sy, dot, z;
    int len;
    offset_t r;
    u[0] = longint'(q.dx) - longint'(q.sx);
    u[1] = longint'(q.dy) - longint'(q.sy);
    u[2] = longint'(q.dz) - longint'(q.sz);
    for (int k = 0; k < 3; k++) mag[k] = u[k] < 0 ? -u[k] : u[k];
    if ((mag[0] | mag[1] | mag[2]) == 0) begin
      r.angle = '0;
      r.degen = 1'b1;
      return r;
    end
    mx = mag[0] > mag[1] ? mag[0] : mag[1];
    if (mag[2] > mx) mx = mag[2];
    len = 0;
    while (len < 64 && (mx >> len) != 0) len++;
    // Normalize so the largest component lies in [2^28, 2^29).
    for (int k = 0; k < 3; k++) begin
      m = len > 29 ? mag[k] >> (len - 29) : mag[k] << (29 - len);
      u[k] = u[k] < 0 ? -longint'(m) : longint'(m);
    end
    cos_sin(longint'(q.pitch), cp, sp);
    cos_sin(longint'(q.yaw), cy, sy);
    v[0] = shr(cp * cy, ONE_BITS);
    v[1] = shr(sy * cp, ONE_BITS);
    v[2] = -sp;
    cr[0] = shr(v[1] * u[2] - v[2] * u[1], ONE_BITS);
    cr[1] = shr(v[2] * u[0] - v[0] * u[2], ONE_BITS);
    cr[2] = shr(v[0] * u[1] - v[1] * u[0], ONE_BITS);
    dot = shr(v[0] * u[0] + v[1] * u[1] + v[2] * u[2], ONE_BITS);
    sq = longint'(cr[0] * cr[0]) + longint'(cr[1] * cr[1]) + longint'(cr[2] * cr[2]);
    z = vector_angle(longint'(int_sqrt(sq)), dot);
    if (z < 0) z = 0;
    z = (z + (64'sd1 <<< (IA_SHIFT - ANGLE_BITS - 1))) >>> (IA_SHIFT - ANGLE_BITS);
    if (z > (64'sd180 <<< ANGLE_BITS)) z = 64'sd180 <<< ANGLE_BITS;
    if (z > 64'sh7FFF) z = 64'sh7FFF;
    r.angle = z[14:0];
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] rand_coord(input int style);
    case (style)
      0: return $urandom;
      1: return $signed($urandom_range(0, 4095)) - 2048;
      2: return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return 16'($signed($urandom_range(0, 46080)) - 23040);
    if (p < 8) return 16'($urandom);
    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  task automatic add_query(input logic signed [15:0] p, input logic signed [15:0] y,
                           input logic signed [31:0] sx, input logic signed [31:0] sy,
                           input logic signed [31:0] sz, input logic signed [31:0] dx,
                           input logic signed [31:0] dy, input logic signed [31:0] dz);
    query_t q;
    q = '{p, y, sx, sy, sz, dx, dy, dz};
    pending_queries.push_back(q);
  endtask

  // Stimulus: directed corner cases, then random queries.
  initial begin
    int st;
    logic signed [31:0] sx, sy, sz;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // Coincident points, including the extremes.
    add_query(0, 0, 0, 0, 0, 0, 0, 0);
    add_query(16'sh7FFF, 16'sh8000, 32'sh7FFFFFFF, 32'sh80000000, 5,
              32'sh7FFFFFFF, 32'sh80000000, 5);
    // Target straight above and below, with any yaw.
    add_query(0, 1234, 0, 0, 0, 0, 0, 256);
    add_query(11520, -777, 0, 0, 0, 0, 0, -256);
    add_query(-11520, 23040, 0, 0, 0, 0, 0, 32'sh7FFFFFFF);
    // Looking straight at and straight away from the target.
    add_query(0, 0, 0, 0, 0, 1000, 0, 0);
    add_query(0, 23040, 0, 0, 0, 1000, 0, 0);
    add_query(0, -23040, 0, 0, 0, 1000, 0, 0);
    add_query(0, 11520, 0, 0, 0, 0, 300, 0);
    add_query(0, -11520, 0, 0, 0, 0, 300, 0);
    // Largest deltas along both diagonal directions, then the smallest deltas.
    add_query(0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    add_query(100, -100, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_query(-23040, 23040, 0, 0, 0, 1, 0, 0);
    add_query(23040, -23040, 0, 0, 0, 0, -1, 1);
    // View angles at the ends of the input range, and near zero.
    add_query(16'sh7FFF, 16'sh7FFF, 10, 20, 30, -40, 50, -60);
    add_query(16'sh8000, 16'sh8000, -10, 20, -30, 40, 50, 60);
    add_query(16'shFFFF, 16'sh0001, 1, 1, 1, 2, 2, 2);
    // Random queries.
    for (int n = 0; n < N_RANDOM; n++) begin
      st = $urandom_range(0, 3);
      sx = rand_coord(st);
      sy = rand_coord(st);
      sz = rand_coord(st);
      case ($urandom_range(0, 19))
        0: add_query(rand_angle(), rand_angle(), sx, sy, sz, sx, sy, sz);
        1: add_query(rand_angle(), rand_angle(), sx, sy, sz, sx, sy, rand_coord(st));
        default: add_query(rand_angle(), rand_angle(), sx, sy, sz,
                           rand_coord(st), rand_coord(st), rand_coord(st));
      endcase
    end
    stimulus_done = 1'b1;
  end

  // Driver: presents queued queries, holding each until accepted.
  always @(negedge clk) begin
    query_t q;
    if (!rst) begin
      if (in_busy) begin
        // Payload holds while the block stalls.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_queries.size() > 0) begin
        q = pending_queries.pop_front();
        view_pitch <= q.pitch;
        view_yaw <= q.yaw;
        src_x <= q.sx;
        src_y <= q.sy;
        src_z <= q.sz;
        dst_x <= q.dx;
        dst_y <= q.dy;
        dst_z <= q.dz;
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off early in the run.
  always @(negedge clk) begin
    if (!rst) begin
      if (cycle_count == 200) begin
        hold_off_left <= 300;
        out_stall <= 1'b1;
      end else if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Monitor: predicts accepted queries and checks results.
  always @(posedge clk) begin
    offset_t want;
    cycle_count <= cycle_count + 1;
    // Remember whether the offered transaction was held off at this edge.
    in_busy <= in_valid && in_stall;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_offsets.push_back(predict_offset('{view_pitch, view_yaw, src_x, src_y,
                                                    src_z, dst_x, dst_y, dst_z}));
      if (out_valid && !out_stall) begin
        if (expected_offsets.size() == 0) begin
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          want = expected_offsets.pop_front();
          if (offset_angle !== want.angle)
            report_mismatch("offset_angle", offset_angle, want.angle);
          if (degenerate !== want.degen)
            report_mismatch("degenerate", degenerate, want.degen);
        end
      end
    end
  end

  // End of run and timeout.
  initial begin
    wait (stimulus_done && pending_queries.size() == 0 && !in_valid
          && expected_offsets.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
